// File: rtl/pbts_pkg.sv
// pbts_pkg: shared types and codes for the postfix boolean tree scorer
// no dependencies
package pbts_pkg;

	localparam int CMD_W = 3;
	localparam int CODE_W = 7;
	localparam int SCORE_W = 20;
	localparam int WEIGHT_W = 16;
	localparam int OUTS_W = 16;
	localparam int ASSIGN_W = 64;
	localparam int FUNC_CODES = 16;

	typedef enum logic [CMD_W-1:0] {
		CMD_WR_TOKEN  = 3'd0,
		CMD_WR_WEIGHT = 3'd1,
		CMD_SET_COUNT = 3'd2,
		CMD_FULL_EVAL = 3'd3,
		CMD_INCR_EVAL = 3'd4,
		CMD_ACCEPT    = 3'd5
	} cmd_t;

	localparam logic [0:0] REG_NUM_VARS = 1'b0;
	localparam logic [CODE_W-1:0] NUM_VARS_RESET = 7'd64;

endpackage

// File: rtl/pbts_if.sv
// pbts_if: valid/ready channel carrying a payload of type T
// depends on nothing; payload type is a parameter
interface pbts_if #(parameter type T = logic) ();
	logic valid;
	logic ready;
	T     data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// File: rtl/pbts_queue.sv
// pbts_queue: small two-entry fifo between front and back
// depends on nothing but its parameter type
module pbts_queue #(
	parameter type T = logic
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  T     in_data,
	output logic out_valid,
	input  logic out_ready,
	output T     out_data
);
	T            mem_q [2];
	logic        wp_q, rp_q;
	logic [1:0]  cnt_q;

	assign in_ready = (cnt_q != 2'd2);
	assign out_valid = (cnt_q != 2'd0);
	assign out_data = mem_q[rp_q];

	// storage
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) mem_q[wp_q] <= in_data;
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (in_valid && in_ready) wp_q <= ~wp_q;
			if (out_valid && out_ready) rp_q <= ~rp_q;
			cnt_q <= cnt_q + 2'(in_valid && in_ready) - 2'(out_valid && out_ready);
		end
	end
endmodule

// File: rtl/pbts_front.sv
// pbts_front: accepts commands, marks unused codes and out-of-range individuals as nop
// depends on pbts_pkg
module pbts_front #(
	parameter int POP_SIZE = 8,
	parameter int IND_W = 3
) (
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [2:0]       in_command,
	input  logic [IND_W-1:0] in_individual,
	output logic             q_valid,
	input  logic             q_ready,
	output logic             q_nop
);
	import pbts_pkg::*;

	// classify: nop means zero result and no state change
	always_comb begin
		q_nop = 1'b0;
		if (32'(in_individual) >= POP_SIZE) q_nop = 1'b1;
		unique case (in_command)
			CMD_WR_TOKEN, CMD_WR_WEIGHT, CMD_SET_COUNT,
			CMD_FULL_EVAL, CMD_INCR_EVAL, CMD_ACCEPT: ;
			default: q_nop = 1'b1;
		endcase
	end

	assign q_valid = in_valid;
	assign in_ready = q_ready;
endmodule

// File: rtl/pbts_back.sv
// pbts_back: executes commands: stores, tree evaluation sequencer, result register
// depends on pbts_pkg
module pbts_back #(
	parameter int POP_SIZE = 8,
	parameter int MAX_TREES = 16,
	parameter int TREE_WIDTH = 16,
	parameter int MAX_VARS = 64,
	parameter int IND_W = 3,
	parameter int TREE_W = 4,
	parameter int POS_W = 4
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          q_valid,
	output logic                          q_ready,
	input  logic                          q_nop,
	input  logic [2:0]                    q_command,
	input  logic [IND_W-1:0]              q_individual,
	input  logic [3:0]                    q_tree_index,
	input  logic [3:0]                    q_token_position,
	input  logic [pbts_pkg::CODE_W-1:0]   q_token_code,
	input  logic                          q_keep_polarity,
	input  logic [15:0]                   q_weight,
	input  logic [4:0]                    q_tree_count,
	input  logic [63:0]                   q_assignment,
	input  logic [5:0]                    q_changed_var,
	input  logic [pbts_pkg::CODE_W-1:0]   num_vars,
	output logic                          r_valid,
	input  logic                          r_ready,
	output logic signed [19:0]            r_score,
	output logic [15:0]                   r_tree_outputs
);
	import pbts_pkg::*;

	localparam int SLOTS = POP_SIZE * MAX_TREES * TREE_WIDTH;
	localparam int WSLOTS = POP_SIZE * MAX_TREES;
	localparam int SADDR_W = IND_W + TREE_W + POS_W;
	localparam int CNT_W = $clog2(MAX_TREES + 1);
	localparam int SP_W = $clog2(TREE_WIDTH + 1);
	localparam int STK_IW = $clog2(TREE_WIDTH);
	localparam int ACC_W = WEIGHT_W + TREE_W + 1;

	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_FETCH = 5'b00010,
		ST_STEP  = 5'b00100,
		ST_TREE  = 5'b01000,
		ST_DONE  = 5'b10000
	} state_t;

	// memories
	logic [CODE_W:0]         tok_mem [SLOTS];
	logic [WEIGHT_W-1:0]     wt_mem [WSLOTS];
	logic [CODE_W:0]         tok_rd_q;
	logic [WEIGHT_W-1:0]     wt_rd_q;
	logic [CNT_W-1:0]        count_q [POP_SIZE];
	logic [MAX_TREES-1:0]    acc_q [POP_SIZE];
	logic [MAX_TREES-1:0]    trial_q [POP_SIZE];

	state_t                  st_q;
	logic                    full_q, tree_live_q, used_q;
	logic [IND_W-1:0]        ind_q;
	logic [TREE_W-1:0]       tree_q;
	logic [CNT_W-1:0]        tcnt_q;
	logic [POS_W:0]          pos_q;
	logic [TREE_WIDTH-1:0]   stk_q;
	logic [SP_W-1:0]         sp_q;
	logic [63:0]             asg_q;
	logic [5:0]              chg_q;
	logic signed [ACC_W-1:0] sum_q;
	logic [MAX_TREES-1:0]    outs_q;
	logic                    busy;

	logic                    accept;
	logic                    is_eval_cmd;
	logic                    r_set;
	logic [SADDR_W-1:0]      rd_addr;
	logic [CODE_W-1:0]       code;
	logic                    keep, is_end, bit_v, val, a_b, b_b;
	logic [1:0]              off;
	logic [SP_W-1:0]         sp1, sp2;
	logic [CODE_W-1:0]       vidx;
	logic [TREE_WIDTH-1:0]   stk_n;
	logic [SP_W-1:0]         sp_n;
	logic                    tree_bit;
	logic signed [ACC_W-1:0] sum_n;
	logic signed [19:0]      sat;
	logic [MAX_TREES-1:0]    mask;
	logic [MAX_TREES-1:0]    cmask, acc_nv;

	assign busy = (st_q != ST_IDLE);
	assign q_ready = !busy && !(r_valid && !r_ready);
	assign accept = q_valid && q_ready;
	assign rd_addr = {ind_q, tree_q, pos_q[POS_W-1:0]};
	assign is_eval_cmd = (cmd_t'(q_command) == CMD_FULL_EVAL)
		|| (cmd_t'(q_command) == CMD_INCR_EVAL);
	assign r_set = (accept && (q_nop || !is_eval_cmd)) || (st_q == ST_DONE);

	// write ports and registered reads
	always_ff @(posedge clk) begin
		if (accept && !q_nop && cmd_t'(q_command) == CMD_WR_TOKEN
			&& 32'(q_tree_index) < MAX_TREES && 32'(q_token_position) < TREE_WIDTH)
			tok_mem[{q_individual, q_tree_index[TREE_W-1:0], q_token_position[POS_W-1:0]}]
				<= {q_keep_polarity, q_token_code};
		if (accept && !q_nop && cmd_t'(q_command) == CMD_WR_WEIGHT
			&& 32'(q_tree_index) < MAX_TREES)
			wt_mem[{q_individual, q_tree_index[TREE_W-1:0]}] <= q_weight;
		tok_rd_q <= tok_mem[rd_addr];
		wt_rd_q <= wt_mem[{ind_q, tree_q}];
	end

	// one token step
	always_comb begin
		code = tok_rd_q[CODE_W-1:0];
		keep = tok_rd_q[CODE_W];
		is_end = ({1'b0, code} >= ({1'b0, num_vars} + 8'(FUNC_CODES)));
		sp1 = (sp_q == '0) ? '0 : sp_q - 1'b1;
		sp2 = (sp1 == '0) ? '0 : sp1 - 1'b1;
		a_b = (sp_q == '0) ? 1'b0 : stk_q[sp1[STK_IW-1:0]];
		b_b = (sp1 == '0) ? 1'b0 : stk_q[sp2[STK_IW-1:0]];
		off = {b_b, a_b};
		vidx = code - 7'(FUNC_CODES);
		if (code >= 7'(FUNC_CODES))
			bit_v = (32'(vidx) < MAX_VARS) ? asg_q[vidx[5:0]] : 1'b0;
		else
			bit_v = code[2'd3 - off];
		val = (bit_v == keep);
		stk_n = stk_q;
		sp_n = (code >= 7'(FUNC_CODES)) ? sp_q : sp2;
		stk_n[sp_n[STK_IW-1:0]] = val;
		sp_n = sp_n + 1'b1;
		tree_bit = (full_q || used_q) ? stk_q[0] : acc_q[ind_q][tree_q];
		sum_n = sum_q + (tree_bit ? ACC_W'(signed'(wt_rd_q)) : '0);
		if (sum_q > 524287) sat = 20'sd524287;
		else if (sum_q < -524288) sat = -20'sd524288;
		else sat = sum_q[19:0];
		mask = '0;
		for (int i = 0; i < MAX_TREES; i++) mask[i] = (i < 32'(count_q[ind_q]));
		// commit value for an accept command
		cmask = '0;
		for (int i = 0; i < MAX_TREES; i++) cmask[i] = (i < 32'(count_q[q_individual]));
		acc_nv = (acc_q[q_individual] & ~cmask) | (trial_q[q_individual] & cmask);
	end

	// result valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) r_valid <= 1'b0;
		else if (r_set) r_valid <= 1'b1;
		else if (r_valid && r_ready) r_valid <= 1'b0;
	end

	// sequencer and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
			r_score <= '0;
			r_tree_outputs <= '0;
			for (int i = 0; i < POP_SIZE; i++) begin
				count_q[i] <= '0;
				acc_q[i] <= '0;
				trial_q[i] <= '0;
			end
			full_q <= 1'b0; ind_q <= '0; tree_q <= '0; tcnt_q <= '0; pos_q <= '0;
			stk_q <= '0; sp_q <= '0; asg_q <= '0; chg_q <= '0; sum_q <= '0;
			outs_q <= '0; used_q <= 1'b0; tree_live_q <= 1'b0;
		end else begin
			unique case (st_q)
				ST_IDLE: begin
					if (accept) begin
						ind_q <= q_individual;
						tree_q <= '0;
						pos_q <= '0;
						stk_q <= '0;
						sp_q <= '0;
						sum_q <= '0;
						outs_q <= '0;
						used_q <= 1'b0;
						tree_live_q <= 1'b1;
						asg_q <= q_assignment;
						chg_q <= q_changed_var;
						full_q <= (cmd_t'(q_command) == CMD_FULL_EVAL);
						tcnt_q <= count_q[q_individual];
						r_score <= '0;
						r_tree_outputs <= (!q_nop && cmd_t'(q_command) == CMD_ACCEPT)
							? 16'(acc_nv) : '0;
						if (!q_nop) begin
							if (is_eval_cmd) begin
								if (count_q[q_individual] == '0) st_q <= ST_DONE;
								else st_q <= ST_FETCH;
							end else begin
								if (cmd_t'(q_command) == CMD_SET_COUNT)
									count_q[q_individual] <= (32'(q_tree_count) > MAX_TREES)
										? CNT_W'(MAX_TREES) : CNT_W'(q_tree_count);
								if (cmd_t'(q_command) == CMD_ACCEPT)
									acc_q[q_individual] <= acc_nv;
							end
						end
					end
				end
				ST_FETCH: st_q <= ST_STEP;
				ST_STEP: begin
					// token read is valid here
					if (tree_live_q && !is_end) begin
						stk_q <= stk_n;
						sp_q <= sp_n;
						if (code == 7'(chg_q) + 7'(FUNC_CODES)) used_q <= 1'b1;
					end
					if (is_end) tree_live_q <= 1'b0;
					if (32'(pos_q) == TREE_WIDTH - 1) st_q <= ST_TREE;
					else begin
						pos_q <= pos_q + 1'b1;
						st_q <= ST_FETCH;
					end
				end
				ST_TREE: begin
					sum_q <= sum_n;
					outs_q[tree_q] <= tree_bit;
					stk_q <= '0;
					sp_q <= '0;
					pos_q <= '0;
					used_q <= 1'b0;
					tree_live_q <= 1'b1;
					if (32'(tree_q) + 1 >= 32'(tcnt_q)) st_q <= ST_DONE;
					else begin
						tree_q <= tree_q + 1'b1;
						st_q <= ST_FETCH;
					end
				end
				ST_DONE: begin
					if (full_q) acc_q[ind_q] <= (acc_q[ind_q] & ~mask) | outs_q;
					else trial_q[ind_q] <= outs_q;
					r_score <= sat;
					r_tree_outputs <= 16'(outs_q);
					st_q <= ST_IDLE;
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end
endmodule

// File: rtl/postfix_boolean_tree_scorer_top.sv
// postfix_boolean_tree_scorer_top: command channel in, score channel out, apb register
// depends on pbts_pkg, pbts_if, pbts_front, pbts_queue, pbts_back
//
// channel   dir  payload
// cmd_in    in   command, individual, tree_index, token_position, token_code,
//                keep_polarity, weight, tree_count, assignment, changed_var
// res_out   out  score, tree_outputs
// apb       in   num_vars at address 0
//
// write/accept commands pass the queue register, then the result register is set;
// evaluations: FETCH and STEP per token of each tree, TREE after each tree, then DONE
// one command is in execution at a time; a two-entry queue holds the next ones
// arst_n clears tree counts, saved outputs and num_vars (64); stores are undefined
// a stalled result register blocks the back end, the queue keeps the front accepting until it holds two entries
module postfix_boolean_tree_scorer_top #(
	parameter int POP_SIZE = 8,
	parameter int MAX_TREES = 16,
	parameter int TREE_WIDTH = 16,
	parameter int MAX_VARS = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	pbts_if.sink        cmd_in,
	pbts_if.source      res_out,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [1:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import pbts_pkg::*;

	typedef struct packed {
		logic [2:0]  command;
		logic [2:0]  individual;
		logic [3:0]  tree_index;
		logic [3:0]  token_position;
		logic [6:0]  token_code;
		logic        keep_polarity;
		logic [15:0] weight;
		logic [4:0]  tree_count;
		logic [63:0] assignment;
		logic [5:0]  changed_var;
		logic        nop;
	} qent_t;

	logic [CODE_W-1:0] num_vars_q;
	logic fq_valid, fq_ready, fq_nop, bq_valid, bq_ready;
	qent_t qin, qout;

	// configuration register
	assign pready = 1'b1;
	assign prdata = (paddr[1] == REG_NUM_VARS) ? 32'(num_vars_q) : '0;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) num_vars_q <= NUM_VARS_RESET;
		else if (psel && penable && pwrite && paddr[1] == REG_NUM_VARS)
			num_vars_q <= pwdata[CODE_W-1:0];
	end

	// front end
	pbts_front #(.POP_SIZE(POP_SIZE), .IND_W(3)) u_front (
		.in_valid(cmd_in.valid), .in_ready(cmd_in.ready),
		.in_command(cmd_in.data.command), .in_individual(cmd_in.data.individual),
		.q_valid(fq_valid), .q_ready(fq_ready), .q_nop(fq_nop)
	);

	always_comb begin
		qin.command = cmd_in.data.command;
		qin.individual = cmd_in.data.individual;
		qin.tree_index = cmd_in.data.tree_index;
		qin.token_position = cmd_in.data.token_position;
		qin.token_code = cmd_in.data.token_code;
		qin.keep_polarity = cmd_in.data.keep_polarity;
		qin.weight = cmd_in.data.weight;
		qin.tree_count = cmd_in.data.tree_count;
		qin.assignment = cmd_in.data.assignment;
		qin.changed_var = cmd_in.data.changed_var;
		qin.nop = fq_nop;
	end

	// decoupling queue
	pbts_queue #(.T(qent_t)) u_queue (
		.clk(clk), .arst_n(arst_n),
		.in_valid(fq_valid), .in_ready(fq_ready), .in_data(qin),
		.out_valid(bq_valid), .out_ready(bq_ready), .out_data(qout)
	);

	// back end
	pbts_back #(.POP_SIZE(POP_SIZE), .MAX_TREES(MAX_TREES), .TREE_WIDTH(TREE_WIDTH),
		.MAX_VARS(MAX_VARS), .IND_W(3), .TREE_W(4), .POS_W(4)) u_back (
		.clk(clk), .arst_n(arst_n),
		.q_valid(bq_valid), .q_ready(bq_ready), .q_nop(qout.nop),
		.q_command(qout.command), .q_individual(qout.individual),
		.q_tree_index(qout.tree_index), .q_token_position(qout.token_position),
		.q_token_code(qout.token_code), .q_keep_polarity(qout.keep_polarity),
		.q_weight(qout.weight), .q_tree_count(qout.tree_count),
		.q_assignment(qout.assignment), .q_changed_var(qout.changed_var),
		.num_vars(num_vars_q),
		.r_valid(res_out.valid), .r_ready(res_out.ready),
		.r_score(res_out.data.score), .r_tree_outputs(res_out.data.tree_outputs)
	);

	// stalled results stay valid; the back end takes one command at a time
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_out.valid && !res_out.ready |=> res_out.valid)
		else $error("result dropped while stalled");
	a_q_take: assert property (@(posedge clk) disable iff (!arst_n)
		bq_valid && bq_ready |=> !bq_ready || !u_back.busy)
		else $error("back end took a command while busy");
endmodule
